[design/ptp_tmr_pkg.sv]
// ----------------------------------------------------------------------------
// PTP timer package
// Shared widths, register indexes, operation codes and the control and status
// structs passed between the top level and the per-unit time counters.
// ----------------------------------------------------------------------------
package ptp_tmr_pkg;

   // Geometry
   localparam int NUM_UNITS     = 2;
   localparam int UNIT_W        = 1;
   localparam int DATA_W        = 32;
   localparam int CPT_W         = 21;
   localparam int FRACTION_BITS = 27;
   localparam int NS_W          = 30;
   localparam int SEC_W         = 48;
   localparam int SEC_HIGH_W    = SEC_W - DATA_W;
   localparam int FRAC_W        = NS_W + FRACTION_BITS;
   localparam int STEP_W        = DATA_W + CPT_W;
   localparam int HALF_SEC_W    = SEC_W / 2;
   localparam int PROD_W        = HALF_SEC_W + NS_W;
   localparam int AVTP_W        = 64;

   // Constants
   localparam logic [CPT_W-1:0]  CPT_RESET     = CPT_W'(250000);
   localparam logic [NS_W-1:0]   NS_PER_SEC    = NS_W'(1000000000);
   localparam logic [FRAC_W-1:0] FRAC_PER_SEC  = FRAC_W'(64'd1000000000 << FRACTION_BITS);
   localparam logic [DATA_W-1:0] VERSION_WORD  = DATA_W'(3);

   typedef logic [3:0] reg_raw_type;

   // Operation codes
   typedef enum logic [1:0] {
      FUNC_READ  = 2'd0,
      FUNC_WRITE = 2'd1,
      FUNC_TICK  = 2'd2
   } func_type;

   // Register indexes
   typedef enum logic [3:0] {
      REG_VERSION   = 4'd0,
      REG_ENABLE    = 4'd1,
      REG_DISABLE   = 4'd2,
      REG_INCREMENT = 4'd3,
      REG_OFFSET_L  = 4'd4,
      REG_OFFSET_M  = 4'd5,
      REG_OFFSET_H  = 4'd6,
      REG_TIME_L    = 4'd7,
      REG_TIME_M    = 4'd8,
      REG_TIME_H    = 4'd9,
      REG_AVTP_L    = 4'd10,
      REG_AVTP_H    = 4'd11
   } reg_idx_type;

   // Command broadcast to every unit for one accepted word
   typedef struct packed {
      logic              rd;
      logic              wr;
      logic              tick;
      reg_idx_type       reg_index;
      logic [DATA_W-1:0] wdata;
   } ptp_cmd_type;

   // Per-unit status seen by the top level
   typedef struct packed {
      logic              enabled;
      logic [DATA_W-1:0] rd_data;
      logic [SEC_W-1:0]  sec;
      logic [NS_W-1:0]   nsec;
   } ptp_stat_type;

endpackage

[design/ptp_tmr_ifs.sv]
// ----------------------------------------------------------------------------
// PTP timer channel interfaces
// Valid/ready channels for register requests and read responses.
// ----------------------------------------------------------------------------
interface ptp_tmr_req_if;
   import ptp_tmr_pkg::*;

   logic                valid;
   logic                ready;
   logic [1:0]          func;
   logic [3:0]          reg_index;
   logic [UNIT_W-1:0]   unit;
   logic [DATA_W-1:0]   write_data;

   modport source (output valid, func, reg_index, unit, write_data, input ready);
   modport sink   (input valid, func, reg_index, unit, write_data, output ready);
endinterface

interface ptp_tmr_rsp_if;
   import ptp_tmr_pkg::*;

   logic                valid;
   logic                ready;
   logic [DATA_W-1:0]   read_data;

   modport source (output valid, read_data, input ready);
   modport sink   (input valid, read_data, output ready);
endinterface

[design/ptp_tmr_unit.sv]
// ----------------------------------------------------------------------------
// PTP timer unit
// One time counter: enable, increment, staged and committed offset, running
// seconds and 30.27 fixed-point sub-second accumulator, time read latches.
// ----------------------------------------------------------------------------
module ptp_tmr_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  ptp_tmr_pkg::ptp_cmd_type            cmd,
   input  logic                                sel,
   input  logic                                mask_bit,
   input  logic [ptp_tmr_pkg::CPT_W-1:0]       cpt_in,
   output ptp_tmr_pkg::ptp_stat_type           stat
);
   import ptp_tmr_pkg::*;

   logic                    en_ff,       en_in;
   logic [DATA_W-1:0]       inc_ff,      inc_in;
   logic [STEP_W-1:0]       step_ff,     step_in;
   logic [DATA_W-1:0]       stl_ff,      stl_in;
   logic [DATA_W-1:0]       stm_ff,      stm_in;
   logic [DATA_W-1:0]       sth_ff,      sth_in;
   logic [SEC_W-1:0]        off_sec_ff,  off_sec_in;
   logic [NS_W-1:0]         off_ns_ff,   off_ns_in;
   logic [SEC_W-1:0]        run_sec_ff,  run_sec_in;
   logic [FRAC_W-1:0]       frac_ff,     frac_in;
   logic [DATA_W-1:0]       lmid_ff,     lmid_in;
   logic [SEC_HIGH_W-1:0]   lhigh_ff,    lhigh_in;

   logic [FRAC_W:0]         frac_sum;
   logic                    frac_wrap;
   logic [FRAC_W-1:0]       frac_tick;
   logic [NS_W:0]           ns_sum;
   logic [NS_W:0]           ns_adj;
   logic                    ns_carry;
   logic [SEC_W-1:0]        cur_sec;
   logic [NS_W-1:0]         cur_nsec;

   // Advance the accumulator by one tick and carry at most one whole second
   always_comb begin
      frac_sum  = {1'b0, frac_ff} + (FRAC_W+1)'(step_ff);
      frac_wrap = frac_sum >= {1'b0, FRAC_PER_SEC};
      frac_tick = frac_wrap ? FRAC_W'(frac_sum - {1'b0, FRAC_PER_SEC})
                            : FRAC_W'(frac_sum);
   end

   // Current time: offset plus running time, one nanosecond fold; zero when stopped
   always_comb begin
      ns_sum   = {1'b0, off_ns_ff} + {1'b0, frac_ff[FRAC_W-1 -: NS_W]};
      ns_carry = ns_sum >= {1'b0, NS_PER_SEC};
      ns_adj   = ns_carry ? ns_sum - {1'b0, NS_PER_SEC} : ns_sum;
      if (en_ff) begin
         cur_sec  = off_sec_ff + run_sec_ff + SEC_W'(ns_carry);
         cur_nsec = ns_adj[NS_W-1:0];
      end else begin
         cur_sec  = '0;
         cur_nsec = '0;
      end
   end

   // Register writes, ticks and time latches
   always_comb begin
      en_in      = en_ff;
      inc_in     = inc_ff;
      stl_in     = stl_ff;
      stm_in     = stm_ff;
      sth_in     = sth_ff;
      off_sec_in = off_sec_ff;
      off_ns_in  = off_ns_ff;
      run_sec_in = run_sec_ff;
      frac_in    = frac_ff;
      lmid_in    = lmid_ff;
      lhigh_in   = lhigh_ff;

      if (cmd.wr) begin
         case (cmd.reg_index)
            REG_ENABLE: begin
               if (mask_bit) en_in = 1'b1;
            end
            REG_DISABLE: begin
               if (mask_bit) begin
                  en_in      = 1'b0;
                  run_sec_in = '0;
                  frac_in    = '0;
               end
            end
            REG_INCREMENT: begin
               if (sel) inc_in = cmd.wdata;
            end
            REG_OFFSET_L: begin
               if (sel) begin
                  stl_in     = cmd.wdata;
                  off_sec_in = {sth_ff[SEC_HIGH_W-1:0], stm_ff};
                  off_ns_in  = cmd.wdata[NS_W-1:0];
               end
            end
            REG_OFFSET_M: begin
               if (sel) stm_in = cmd.wdata;
            end
            REG_OFFSET_H: begin
               if (sel) sth_in = cmd.wdata;
            end
            default: begin
            end
         endcase
      end

      if (cmd.tick && en_ff) begin
         frac_in    = frac_tick;
         run_sec_in = run_sec_ff + SEC_W'(frac_wrap);
      end

      if (cmd.rd && sel && cmd.reg_index == REG_TIME_L) begin
         lmid_in  = cur_sec[DATA_W-1:0];
         lhigh_in = cur_sec[SEC_W-1:DATA_W];
      end

      // Keep the per-tick step ready for the next word
      step_in = STEP_W'(inc_in) * STEP_W'(cpt_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff      <= 1'b0;
         inc_ff     <= '0;
         step_ff    <= '0;
         stl_ff     <= '0;
         stm_ff     <= '0;
         sth_ff     <= '0;
         off_sec_ff <= '0;
         off_ns_ff  <= '0;
         run_sec_ff <= '0;
         frac_ff    <= '0;
         lmid_ff    <= '0;
         lhigh_ff   <= '0;
      end else begin
         en_ff      <= en_in;
         inc_ff     <= inc_in;
         step_ff    <= step_in;
         stl_ff     <= stl_in;
         stm_ff     <= stm_in;
         sth_ff     <= sth_in;
         off_sec_ff <= off_sec_in;
         off_ns_ff  <= off_ns_in;
         run_sec_ff <= run_sec_in;
         frac_ff    <= frac_in;
         lmid_ff    <= lmid_in;
         lhigh_ff   <= lhigh_in;
      end
   end

   // Local register read-back
   always_comb begin
      stat.enabled = en_ff;
      stat.sec     = cur_sec;
      stat.nsec    = cur_nsec;
      case (cmd.reg_index)
         REG_INCREMENT: stat.rd_data = inc_ff;
         REG_OFFSET_L:  stat.rd_data = stl_ff;
         REG_OFFSET_M:  stat.rd_data = stm_ff;
         REG_OFFSET_H:  stat.rd_data = sth_ff;
         REG_TIME_L:    stat.rd_data = DATA_W'(cur_nsec);
         REG_TIME_M:    stat.rd_data = lmid_ff;
         REG_TIME_H:    stat.rd_data = DATA_W'(lhigh_ff);
         default:       stat.rd_data = '0;
      endcase
   end

endmodule

[design/ptp_timer_counter_regs.sv]
// ----------------------------------------------------------------------------
// PTP timer counter registers
// Register front end for the PTP time counters with a three-stage read path.
// ----------------------------------------------------------------------------
// One register read, register write or tick is accepted every clock while the
// response side does not stall, and each word returns exactly one read word
// through stage A, stage B and the output stage. All state changes take effect
// at acceptance: a tick adds the precomputed increment times clocks_per_tick
// step to each enabled unit's 57-bit accumulator with one add and compare, so
// ticks can arrive back to back. The AVTP nanosecond view (seconds times 1e9
// plus nanoseconds) is formed over the two following stages as two 24 by 30
// bit partial products and one 64-bit add; the AVTP high latch is written and
// read at the final stage. No clearing pass follows reset.
module ptp_timer_counter_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [ptp_tmr_pkg::CPT_W-1:0]       csr_wdata,
   ptp_tmr_req_if.sink                         req_ch,
   ptp_tmr_rsp_if.source                       rsp_ch
);
   import ptp_tmr_pkg::*;

   typedef enum logic [1:0] {
      KIND_PLAIN,
      KIND_AVTP_LO,
      KIND_AVTP_HI
   } rd_kind_type;

   logic [CPT_W-1:0]      cpt_ff, cpt_in;

   logic                  ready_a, ready_b, ready_out;
   logic                  accept, a_go, b_go;
   logic                  unit_ok;
   func_type              func;
   reg_idx_type           reg_index;
   ptp_cmd_type           cmd;
   ptp_stat_type          stat [NUM_UNITS];
   logic [NUM_UNITS-1:0]  en_mask;
   logic [DATA_W-1:0]     rd_value;
   rd_kind_type           rd_kind;

   logic                  a_valid_ff, a_valid_in;
   rd_kind_type           a_kind_ff,  a_kind_in;
   logic [DATA_W-1:0]     a_data_ff,  a_data_in;
   logic [SEC_W-1:0]      a_sec_ff,   a_sec_in;
   logic [NS_W-1:0]       a_nsec_ff,  a_nsec_in;
   logic [UNIT_W-1:0]     a_unit_ff,  a_unit_in;

   logic                  b_valid_ff, b_valid_in;
   rd_kind_type           b_kind_ff,  b_kind_in;
   logic [DATA_W-1:0]     b_data_ff,  b_data_in;
   logic [PROD_W-1:0]     b_plo_ff,   b_plo_in;
   logic [PROD_W-1:0]     b_phi_ff,   b_phi_in;
   logic [NS_W-1:0]       b_nsec_ff,  b_nsec_in;
   logic [UNIT_W-1:0]     b_unit_ff,  b_unit_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]     rsp_data_ff,  rsp_data_in;
   logic [DATA_W-1:0]     avtp_hi_ff [NUM_UNITS];
   logic [DATA_W-1:0]     avtp_hi_in [NUM_UNITS];
   logic [AVTP_W-1:0]     avtp;

   // Stage handshakes
   assign ready_out    = !rsp_valid_ff || rsp_ch.ready;
   assign ready_b      = !b_valid_ff || ready_out;
   assign ready_a      = !a_valid_ff || ready_b;
   assign b_go         = b_valid_ff && ready_out;
   assign a_go         = a_valid_ff && ready_b;
   assign accept       = req_ch.valid && ready_a;
   assign req_ch.ready = ready_a;

   // Decode the incoming word
   assign func      = func_type'(req_ch.func);
   assign reg_index = reg_idx_type'(req_ch.reg_index);
   assign unit_ok   = 32'(req_ch.unit) < NUM_UNITS;

   always_comb begin
      cmd.rd        = accept && func == FUNC_READ;
      cmd.wr        = accept && func == FUNC_WRITE;
      cmd.tick      = accept && func == FUNC_TICK;
      cmd.reg_index = reg_index;
      cmd.wdata     = req_ch.write_data;
   end

   // Clock-per-tick register
   assign cpt_in = csr_we ? csr_wdata : cpt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cpt_ff <= CPT_RESET;
      end else begin
         cpt_ff <= cpt_in;
      end
   end

   // Timer units
   for (genvar k = 0; k < NUM_UNITS; k++) begin : g_unit
      ptp_tmr_unit u_unit (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .sel      (unit_ok && 32'(req_ch.unit) == k),
         .mask_bit (req_ch.write_data[k]),
         .cpt_in   (cpt_in),
         .stat     (stat[k])
      );
      assign en_mask[k] = stat[k].enabled;
   end

   // Select the read word at acceptance
   always_comb begin
      rd_value = '0;
      rd_kind  = KIND_PLAIN;
      if (func == FUNC_READ) begin
         case (reg_index)
            REG_VERSION: rd_value = VERSION_WORD;
            REG_ENABLE:  rd_value = DATA_W'(en_mask);
            REG_INCREMENT, REG_OFFSET_L, REG_OFFSET_M, REG_OFFSET_H,
            REG_TIME_L, REG_TIME_M, REG_TIME_H: begin
               if (unit_ok) rd_value = stat[req_ch.unit].rd_data;
            end
            REG_AVTP_L: begin
               if (unit_ok) rd_kind = KIND_AVTP_LO;
            end
            REG_AVTP_H: begin
               if (unit_ok) rd_kind = KIND_AVTP_HI;
            end
            default: rd_value = '0;
         endcase
      end
   end

   // Stage A: capture read word and time snapshot
   always_comb begin
      a_valid_in = accept || (a_valid_ff && !a_go);
      a_kind_in  = a_kind_ff;
      a_data_in  = a_data_ff;
      a_sec_in   = a_sec_ff;
      a_nsec_in  = a_nsec_ff;
      a_unit_in  = a_unit_ff;
      if (accept) begin
         a_kind_in = rd_kind;
         a_data_in = rd_value;
         a_sec_in  = stat[req_ch.unit].sec;
         a_nsec_in = stat[req_ch.unit].nsec;
         a_unit_in = req_ch.unit;
      end
   end

   // Stage B: seconds times 1e9 as two partial products
   always_comb begin
      b_valid_in = a_go || (b_valid_ff && !b_go);
      b_kind_in  = b_kind_ff;
      b_data_in  = b_data_ff;
      b_plo_in   = b_plo_ff;
      b_phi_in   = b_phi_ff;
      b_nsec_in  = b_nsec_ff;
      b_unit_in  = b_unit_ff;
      if (a_go) begin
         b_kind_in = a_kind_ff;
         b_data_in = a_data_ff;
         b_plo_in  = PROD_W'(a_sec_ff[HALF_SEC_W-1:0]) * PROD_W'(NS_PER_SEC);
         b_phi_in  = PROD_W'(a_sec_ff[SEC_W-1:HALF_SEC_W]) * PROD_W'(NS_PER_SEC);
         b_nsec_in = a_nsec_ff;
         b_unit_in = a_unit_ff;
      end
   end

   // Output stage: finish the AVTP sum, update and read its high latch
   assign avtp = AVTP_W'(b_plo_ff) + (AVTP_W'(b_phi_ff) << HALF_SEC_W)
                 + AVTP_W'(b_nsec_ff);

   always_comb begin
      rsp_valid_in = b_go || (rsp_valid_ff && !rsp_ch.ready);
      rsp_data_in  = rsp_data_ff;
      avtp_hi_in   = avtp_hi_ff;
      if (b_go) begin
         case (b_kind_ff)
            KIND_AVTP_LO: begin
               rsp_data_in           = avtp[DATA_W-1:0];
               avtp_hi_in[b_unit_ff] = avtp[AVTP_W-1:DATA_W];
            end
            KIND_AVTP_HI: rsp_data_in = avtp_hi_ff[b_unit_ff];
            default:      rsp_data_in = b_data_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         avtp_hi_ff   <= '{default: '0};
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         avtp_hi_ff   <= avtp_hi_in;
      end
   end

   // Pipeline payload
   always_ff @(posedge clock) begin
      a_kind_ff   <= a_kind_in;
      a_data_ff   <= a_data_in;
      a_sec_ff    <= a_sec_in;
      a_nsec_ff   <= a_nsec_in;
      a_unit_ff   <= a_unit_in;
      b_kind_ff   <= b_kind_in;
      b_data_ff   <= b_data_in;
      b_plo_ff    <= b_plo_in;
      b_phi_ff    <= b_phi_in;
      b_nsec_ff   <= b_nsec_in;
      b_unit_ff   <= b_unit_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.read_data = rsp_data_ff;

endmodule

[design/ptp_tmr_checker.sv]
// ----------------------------------------------------------------------------
// PTP timer port checker
// Watches the top-level ports for reset, response hold and fixed-latency
// read words of known value.
// ----------------------------------------------------------------------------
module ptp_tmr_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [1:0]                          req_func,
   input  logic [3:0]                          req_reg_index,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [ptp_tmr_pkg::DATA_W-1:0]      rsp_read_data
);
   import ptp_tmr_pkg::*;

   localparam int LATENCY = 3;

   logic req_acc;
   logic ver_acc;
   logic nonread_acc;

   assign req_acc     = req_valid && req_ready;
   assign ver_acc     = req_acc && req_func == FUNC_READ && req_reg_index == REG_VERSION;
   assign nonread_acc = req_acc && req_func != FUNC_READ;

   // Reset empties the response stage
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data))
      else $error("stalled response changed");

   // A version read returns the version word after the fixed latency
   a_version_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && $past(ver_acc, LATENCY)
      && $past(rsp_ready, 1) && $past(rsp_ready, 2)
      |-> rsp_read_data == VERSION_WORD)
      else $error("version read returned wrong word");

   // Writes, ticks and unknown operations return zero
   a_nonread_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && $past(nonread_acc, LATENCY)
      && $past(rsp_ready, 1) && $past(rsp_ready, 2)
      |-> rsp_read_data == '0)
      else $error("non-read word returned nonzero data");

endmodule

bind ptp_timer_counter_regs ptp_tmr_checker u_ptp_tmr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .req_func      (req_ch.func),
   .req_reg_index (req_ch.reg_index),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_read_data (rsp_ch.read_data)
);
